>>> design/fprs_pkg.sv
package fprs_pkg;

	localparam int unsigned NUM_SECTORS          = 17;
	localparam int unsigned PAGES_PER_BLOCK      = 8;
	localparam int unsigned FIRST_SECTOR_BLOCKS  = 1;
	localparam int unsigned SECOND_SECTOR_BLOCKS = 31;
	localparam int unsigned SECTOR_BLOCKS        = 32;

	localparam int unsigned PAGE_W    = 16;
	localparam int unsigned SECTOR_W  = 5;
	localparam int unsigned REFP_W    = 12;
	localparam int unsigned CNT_W     = 8;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 24;

	localparam int unsigned SEC_W = $clog2(NUM_SECTORS);
	// page arithmetic one bit wider than a page number so base + counter never wraps
	localparam int unsigned PX_W  = PAGE_W + 1;
	localparam int unsigned LIM_W = CNT_W + 1;
	localparam int unsigned CNT_MAX = 1 << CNT_W;

	function automatic int unsigned sect_pages(int unsigned s);
		int unsigned blocks;
		if (s == 0)
			blocks = FIRST_SECTOR_BLOCKS;
		else if (s == 1)
			blocks = SECOND_SECTOR_BLOCKS;
		else
			blocks = SECTOR_BLOCKS;
		return blocks * PAGES_PER_BLOCK;
	endfunction

	function automatic int unsigned sect_base(int unsigned s);
		int unsigned acc;
		acc = 0;
		for (int unsigned i = 0; i < s; i++)
			acc = acc + sect_pages(i);
		return acc;
	endfunction

	// counter wraps at the sector size, or at the counter range if smaller
	function automatic int unsigned sect_lim(int unsigned s);
		int unsigned p;
		p = sect_pages(s);
		return (p > CNT_MAX) ? CNT_MAX : p;
	endfunction

	typedef struct packed {
		logic             in_range;
		logic [SEC_W-1:0] sector;
		logic [PX_W-1:0]  base;
		logic [LIM_W-1:0] lim;
	} look_t;

endpackage

>>> design/fprs_ram.sv
module fprs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> design/fprs_lookup.sv
module fprs_lookup (
	input  logic [fprs_pkg::PAGE_W-1:0] page,
	output fprs_pkg::look_t             look
);
	import fprs_pkg::*;

	logic [PX_W-1:0] page_x;

	assign page_x = {1'b0, page};

	// one comparator pair per sector against fixed borders; at most one hits
	always_comb begin
		look = '0;
		for (int unsigned s = 0; s < NUM_SECTORS; s++) begin
			if (page_x >= PX_W'(sect_base(s)) && page_x < PX_W'(sect_base(s + 1))) begin
				look.in_range = 1'b1;
				look.sector   = SEC_W'(s);
				look.base     = PX_W'(sect_base(s));
				look.lim      = LIM_W'(sect_lim(s));
			end
		end
	end

endmodule

>>> design/flash_page_refresh_scheduler.sv
// Channel  Dir  Fields (tdata, lowest bit first)
// s_axis   in   written_page[15:0]
// m_axis   out  in_range[0], sector_index[5:1], refresh_page[17:6], refresh_needed[18]
//
// One request per cycle while m_axis does not stall; stage 1 feeds the result register.
// Stage 1 decodes the sector and reads its counter from the RAM; stage 2 bumps it
// and writes back, with a bypass of the last write for back-to-back hits.
// Reset clears per-sector valid bits, so counters read as zero until written.
// An m_axis stall holds both stages; s_tready drops only when both are full.
module flash_page_refresh_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fprs_pkg::IN_DATA_W-1:0]  s_tdata,  // written_page
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fprs_pkg::OUT_DATA_W-1:0] m_tdata   // in_range, sector_index, refresh_page, refresh_needed
);
	import fprs_pkg::*;

	look_t             look_in;
	look_t             look_s1;
	logic [PAGE_W-1:0] page_s1;
	logic              vld_s1;

	logic              in_acc, out_free, adv;
	logic              ram_we;
	logic [CNT_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]  cnt_cur, cnt_nxt;
	logic [LIM_W-1:0]  cnt_inc;
	logic [PX_W-1:0]   refp;

	logic [NUM_SECTORS-1:0] cnt_vld_q;
	logic                   fwd_vld_q;
	logic [SEC_W-1:0]       fwd_sec_q;
	logic [CNT_W-1:0]       fwd_cnt_q;

	logic                out_vld_q;
	logic                out_rng_q;
	logic [SECTOR_W-1:0] out_sec_q;
	logic [REFP_W-1:0]   out_refp_q;
	logic                out_need_q;

	assign out_free = !out_vld_q || m_tready;
	assign adv      = vld_s1 && out_free;
	assign s_tready = !vld_s1 || out_free;
	assign in_acc   = s_tvalid && s_tready;

	fprs_lookup u_lookup (
		.page (s_tdata[PAGE_W-1:0]),
		.look (look_in)
	);

	assign ram_we = adv && look_s1.in_range;

	fprs_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_SECTORS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (look_s1.sector),
		.wdata (cnt_nxt),
		.re    (in_acc),
		.raddr (look_in.sector),
		.rdata (ram_rdata)
	);

	// last write wins over the RAM, which may have been read in the same cycle
	always_comb begin
		if (fwd_vld_q && fwd_sec_q == look_s1.sector)
			cnt_cur = fwd_cnt_q;
		else if (cnt_vld_q[look_s1.sector])
			cnt_cur = ram_rdata;
		else
			cnt_cur = '0;
	end

	assign cnt_inc = {1'b0, cnt_cur} + LIM_W'(1);
	assign cnt_nxt = (cnt_inc >= look_s1.lim) ? '0 : cnt_inc[CNT_W-1:0];
	assign refp    = look_s1.base + PX_W'(cnt_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			cnt_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (out_free)
				out_vld_q <= vld_s1;
			if (ram_we) begin
				cnt_vld_q[look_s1.sector] <= 1'b1;
				fwd_vld_q                 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			look_s1 <= look_in;
			page_s1 <= s_tdata[PAGE_W-1:0];
		end
		if (ram_we) begin
			fwd_sec_q <= look_s1.sector;
			fwd_cnt_q <= cnt_nxt;
		end
		if (adv) begin
			out_rng_q <= look_s1.in_range;
			if (look_s1.in_range) begin
				out_sec_q  <= SECTOR_W'(look_s1.sector);
				out_refp_q <= refp[REFP_W-1:0];
				out_need_q <= (refp != {1'b0, page_s1});
			end else begin
				out_sec_q  <= '0;
				out_refp_q <= '0;
				out_need_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {
		(OUT_DATA_W - 1 - SECTOR_W - REFP_W - 1)'(0),
		out_need_q, out_refp_q, out_sec_q, out_rng_q
	};

	a_cnt_below_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && look_s1.in_range) |-> ({1'b0, cnt_cur} < look_s1.lim))
		else $error("counter at or beyond its sector wrap");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_rng_q) |-> (out_sec_q == '0 && out_refp_q == '0 && !out_need_q))
		else $error("out-of-range result carries nonzero fields");

	a_no_write_oor: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (vld_s1 && look_s1.in_range && out_free))
		else $error("counter write without an in-range request moving out");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!vld_s1 || !out_vld_q) |-> s_tready)
		else $error("input stalled with a free pipeline slot");

endmodule
